>>> hw/rtl/bm25_pkg.sv
// Shared types and constants for the BM25 score accumulator.
// Used by the configuration block, the divider and the top level.
// No dependencies.
package bm25_pkg;

	// Register map, word index on the configuration port
	typedef enum logic [1:0] {
		REG_TOTAL_DOCS = 2'd0,
		REG_K1         = 2'd1,
		REG_B          = 2'd2,
		REG_AVG_LEN    = 2'd3
	} reg_idx_t;

	// Register values after reset
	localparam logic [31:0] TOTAL_DOCS_RST = 32'd1;
	localparam logic [13:0] K1_RST         = 14'd4915;
	localparam logic [16:0] B_RST          = 17'd49152;
	localparam logic [31:0] AVG_LEN_RST    = 32'd256;

	// Fixed-point constants
	localparam logic [31:0] LN2_Q32   = 32'd2977044472;
	localparam logic [16:0] ONE_Q16   = 17'd65536;
	localparam logic [31:0] AVG_MIN   = 32'd256;
	localparam logic [14:0] K1_PLUS   = 15'd4096;
	localparam logic [4:0]  LOG_STEPS = 5'd16;

	// Divider iteration counts: len/avg and the tf' quotient
	localparam logic [5:0] DIV_LONG_STEPS  = 6'd48;
	localparam logic [5:0] DIV_SHORT_STEPS = 6'd20;

	// Configuration as seen by the datapath
	typedef struct packed {
		logic [31:0] total_docs;
		logic [13:0] k1_q12;
		logic [16:0] b_q16;
		logic [31:0] avg_doc_length_q8;
	} cfg_t;

	// Divider request
	typedef struct packed {
		logic start;
		logic long_mode;
	} div_req_t;

endpackage

>>> hw/rtl/bm25_if.sv
// Valid/ready channel interfaces for term words and score words.
// No dependencies.
interface bm25_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] term_freq;
	logic [31:0] doc_freq;
	logic [31:0] doc_length;
	logic        new_doc;

	modport source (output valid, term_freq, doc_freq, doc_length, new_doc, input ready);
	modport sink (input valid, term_freq, doc_freq, doc_length, new_doc, output ready);
endinterface

interface bm25_out_if;
	logic               valid;
	logic               ready;
	logic signed [47:0] score;

	modport source (output valid, score, input ready);
	modport sink (input valid, score, output ready);
endinterface

>>> hw/rtl/bm25_cfg.sv
// APB register file for N, k1, b and the average document length.
// Depends on bm25_pkg.
module bm25_cfg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output bm25_pkg::cfg_t      cfg
);

	bm25_pkg::cfg_t cfg_q;
	bm25_pkg::reg_idx_t idx;

	assign idx = bm25_pkg::reg_idx_t'(paddr[3:2]);

	// Write on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total_docs        <= bm25_pkg::TOTAL_DOCS_RST;
			cfg_q.k1_q12            <= bm25_pkg::K1_RST;
			cfg_q.b_q16             <= bm25_pkg::B_RST;
			cfg_q.avg_doc_length_q8 <= bm25_pkg::AVG_LEN_RST;
		end else if (psel && penable && pwrite) begin
			case (idx)
				bm25_pkg::REG_TOTAL_DOCS: cfg_q.total_docs        <= pwdata;
				bm25_pkg::REG_K1:         cfg_q.k1_q12            <= pwdata[13:0];
				bm25_pkg::REG_B:          cfg_q.b_q16             <= pwdata[16:0];
				bm25_pkg::REG_AVG_LEN:    cfg_q.avg_doc_length_q8 <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back
	always_comb begin
		case (idx)
			bm25_pkg::REG_TOTAL_DOCS: prdata = cfg_q.total_docs;
			bm25_pkg::REG_K1:         prdata = {18'd0, cfg_q.k1_q12};
			bm25_pkg::REG_B:          prdata = {15'd0, cfg_q.b_q16};
			bm25_pkg::REG_AVG_LEN:    prdata = cfg_q.avg_doc_length_q8;
			default:                  prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

>>> hw/rtl/bm25_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// No dependencies.
module bm25_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p_q
);

	// Register the product every cycle; the sequencer picks the operands
	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

endmodule

>>> hw/rtl/bm25_div.sv
// Restoring divider, one quotient bit per cycle, 48 or 20 iterations.
// The dividend must be below divisor << iterations. Depends on bm25_pkg.
module bm25_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bm25_pkg::div_req_t  req,
	input  logic [63:0]         dividend,
	input  logic [63:0]         divisor,
	output logic                busy,
	output logic [47:0]         quot
);

	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dsr_q;
	logic [47:0] quot_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [64:0] rem_sh;
	logic        ge;

	assign rem_sh = {rem_q, dvd_q[63]};
	assign ge     = rem_sh >= {1'b0, dsr_q};

	// Control: count iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.long_mode ? bm25_pkg::DIV_LONG_STEPS : bm25_pkg::DIV_SHORT_STEPS;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath: load top bits as partial remainder, shift in the rest
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.long_mode ? (dividend >> 48) : (dividend >> 20);
			dvd_q  <= req.long_mode ? (dividend << 16) : (dividend << 44);
			dsr_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? 64'(rem_sh - {1'b0, dsr_q}) : rem_sh[63:0];
			dvd_q  <= {dvd_q[62:0], 1'b0};
			quot_q <= {quot_q[46:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

>>> hw/rtl/bm25_score_accumulator.sv
// BM25 term weight and running document score, top level.
// Depends on bm25_pkg, bm25_if, bm25_cfg, bm25_mul and bm25_div.
//
//  channel   dir  handshake          word
//  term_in   in   valid/ready        term_freq, doc_freq, doc_length, new_doc
//  score_out out  valid/ready        score (signed Q31.16)
//  apb       in   psel/penable       paddr, pwdata, prdata, pready
//
// From accept to the next accept a term goes through the accept, two log2
// passes on the shared multiplier (6 normalize steps, a squaring setup, 16
// squarings), the idf multiply and round, a step that waits for and takes
// len/avg, 7 norm and denominator steps, a wait on the 20-iteration tf'
// division, and the round and accumulate steps. len/avg runs on the divider
// (48 iterations) alongside the log passes. term_in is ready only when the
// sequencer is idle; the score word is registered, the next term is taken
// while it waits, and a held score word stalls only the accumulate step.
// Reset clears the score and restores the register defaults.
module bm25_score_accumulator (
	input  logic              clk,
	input  logic              arst_n,
	bm25_in_if.sink           term_in,
	bm25_out_if.source        score_out,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_NORM  = 17'h00002,
		S_SQ0   = 17'h00004,
		S_SQ    = 17'h00008,
		S_IDF   = 17'h00010,
		S_IDFR  = 17'h00020,
		S_RWAIT = 17'h00040,
		S_N1    = 17'h00080,
		S_N2    = 17'h00100,
		S_N3    = 17'h00200,
		S_K1    = 17'h00400,
		S_K2    = 17'h00800,
		S_K3    = 17'h01000,
		S_K4    = 17'h02000,
		S_TWAIT = 17'h04000,
		S_W     = 17'h08000,
		S_ACC   = 17'h10000
	} state_t;

	state_t state_q;

	bm25_pkg::cfg_t     cfg;
	bm25_pkg::div_req_t div_req;
	logic               div_busy;
	logic [47:0]        div_quot;
	logic [63:0]        div_dividend;
	logic [63:0]        div_divisor;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [63:0]        p_q;

	logic [15:0]        tf_q;
	logic [31:0]        df_q;
	logic               new_doc_q;
	logic [33:0]        x_q;
	logic [5:0]         sh_q;
	logic [2:0]         step_q;
	logic [4:0]         cnt_q;
	logic [15:0]        frac_q;
	logic               second_q;
	logic [21:0]        la_q;
	logic [21:0]        lb_q;
	logic               neg_q;
	logic [21:0]        idf_mag_q;
	logic [47:0]        r_q;
	logic [49:0]        norm_q;
	logic [63:0]        den_q;
	logic               den_zero_q;
	logic [26:0]        wmag_q;
	logic signed [47:0] score_q;
	logic               out_v_q;

	logic               accept;
	logic [31:0]        df_c;
	logic [31:0]        len_c;
	logic [31:0]        avg_c;
	logic [16:0]        b_c;
	logic [33:0]        nx;
	logic [5:0]         nadd;
	logic [31:0]        m2;
	logic               sqbit;
	logic [30:0]        mnext;
	logic [15:0]        frac_nx;
	logic [21:0]        log_val;
	logic [21:0]        dmag;
	logic [54:0]        idf_rnd;
	logic [42:0]        w_rnd;
	logic [19:0]        tfp_c;
	logic signed [48:0] base;
	logic signed [48:0] wsgn;
	logic signed [48:0] sum;
	logic signed [47:0] sum_sat;

	assign pready = 1'b1;

	bm25_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	bm25_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (p_q)
	);

	bm25_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	// Clamp small statistics and b
	assign df_c  = (term_in.doc_freq == 32'd0) ? 32'd1 : term_in.doc_freq;
	assign len_c = (term_in.doc_length == 32'd0) ? 32'd1 : term_in.doc_length;
	assign avg_c = (cfg.avg_doc_length_q8 < bm25_pkg::AVG_MIN) ? bm25_pkg::AVG_MIN
		: cfg.avg_doc_length_q8;
	assign b_c   = (cfg.b_q16 > bm25_pkg::ONE_Q16) ? bm25_pkg::ONE_Q16 : cfg.b_q16;

	assign term_in.ready = (state_q == S_IDLE);
	assign accept        = term_in.valid && term_in.ready;

	// Start len/avg at accept, tf' after the denominator is built
	assign div_req.start     = accept || (state_q == S_K4);
	assign div_req.long_mode = (state_q == S_IDLE);
	assign div_dividend = (state_q == S_IDLE) ? {8'd0, len_c, 24'd0} : {1'b0, p_q[30:0], 32'd0};
	assign div_divisor  = (state_q == S_IDLE) ? {32'd0, avg_c} : den_q;

	// Normalize step: binary search for the top set bit
	always_comb begin
		nx   = x_q;
		nadd = 6'd0;
		case (step_q)
			3'd0: if (x_q[33:2] == '0) begin nx = {x_q[1:0], 32'd0}; nadd = 6'd32; end
			3'd1: if (x_q[33:18] == '0) begin nx = {x_q[17:0], 16'd0}; nadd = 6'd16; end
			3'd2: if (x_q[33:26] == '0) begin nx = {x_q[25:0], 8'd0}; nadd = 6'd8; end
			3'd3: if (x_q[33:30] == '0) begin nx = {x_q[29:0], 4'd0}; nadd = 6'd4; end
			3'd4: if (x_q[33:32] == '0) begin nx = {x_q[31:0], 2'd0}; nadd = 6'd2; end
			3'd5: if (!x_q[33]) begin nx = {x_q[32:0], 1'b0}; nadd = 6'd1; end
			default: ;
		endcase
	end

	// Squaring step: one fraction bit per square
	assign m2      = p_q[61:30];
	assign sqbit   = m2[31];
	assign mnext   = sqbit ? m2[31:1] : m2[30:0];
	assign frac_nx = {frac_q[14:0], sqbit};
	assign log_val = {6'd33 - sh_q, frac_nx};

	assign dmag    = (lb_q > la_q) ? (lb_q - la_q) : (la_q - lb_q);
	assign idf_rnd = {1'b0, p_q[53:0]} + 55'h0_0000_8000_0000;
	assign w_rnd   = {1'b0, p_q[41:0]} + 43'd32768;
	assign tfp_c   = den_zero_q ? 20'd0 : div_quot[19:0];

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_SQ0: begin
				mul_a = {1'b0, x_q[33:3]};
				mul_b = {1'b0, x_q[33:3]};
			end
			S_SQ: begin
				mul_a = {1'b0, mnext};
				mul_b = {1'b0, mnext};
			end
			S_IDF: begin
				mul_a = {10'd0, dmag};
				mul_b = bm25_pkg::LN2_Q32;
			end
			S_N1: begin
				mul_a = {15'd0, b_c};
				mul_b = r_q[47:16];
			end
			S_N2: begin
				mul_a = {15'd0, b_c};
				mul_b = {16'd0, r_q[15:0]};
			end
			S_K1: begin
				mul_a = {18'd0, cfg.k1_q12};
				mul_b = norm_q[31:0];
			end
			S_K2: begin
				mul_a = {18'd0, cfg.k1_q12};
				mul_b = {14'd0, norm_q[49:32]};
			end
			S_K3: begin
				mul_a = {17'd0, 15'({1'b0, cfg.k1_q12} + bm25_pkg::K1_PLUS)};
				mul_b = {16'd0, tf_q};
			end
			S_TWAIT: begin
				mul_a = {10'd0, idf_mag_q};
				mul_b = {12'd0, tfp_c};
			end
			default: ;
		endcase
	end

	// Add the signed weight to the score, or to zero on a new document, and saturate to 48 bits
	assign base = new_doc_q ? 49'sd0 : 49'(score_q);
	assign wsgn = neg_q ? -$signed({22'd0, wmag_q}) : $signed({22'd0, wmag_q});
	assign sum  = base + wsgn;
	assign sum_sat = (sum[48] != sum[47]) ? (sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}})
		: sum[47:0];

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			step_q   <= '0;
			cnt_q    <= '0;
			second_q <= 1'b0;
			score_q  <= '0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && score_out.ready && (state_q != S_ACC)) begin
				out_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: if (accept) begin
					step_q   <= '0;
					second_q <= 1'b0;
					state_q  <= S_NORM;
				end
				S_NORM: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd5) begin
						state_q <= S_SQ0;
					end
				end
				S_SQ0: begin
					cnt_q   <= '0;
					state_q <= S_SQ;
				end
				S_SQ: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == bm25_pkg::LOG_STEPS - 5'd1) begin
						if (second_q) begin
							state_q <= S_IDF;
						end else begin
							second_q <= 1'b1;
							step_q   <= '0;
							state_q  <= S_NORM;
						end
					end
				end
				S_IDF:   state_q <= S_IDFR;
				S_IDFR:  state_q <= S_RWAIT;
				S_RWAIT: if (!div_busy) begin
					state_q <= S_N1;
				end
				S_N1:    state_q <= S_N2;
				S_N2:    state_q <= S_N3;
				S_N3:    state_q <= S_K1;
				S_K1:    state_q <= S_K2;
				S_K2:    state_q <= S_K3;
				S_K3:    state_q <= S_K4;
				S_K4:    state_q <= S_TWAIT;
				S_TWAIT: if (!div_busy) begin
					state_q <= S_W;
				end
				S_W:     state_q <= S_ACC;
				S_ACC: if (!out_v_q || score_out.ready) begin
					score_q <= sum_sat;
					out_v_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (accept) begin
				tf_q      <= term_in.term_freq;
				df_q      <= df_c;
				new_doc_q <= term_in.new_doc;
				x_q       <= 34'({1'b0, cfg.total_docs, 1'b0} + 34'd2);
				sh_q      <= '0;
			end
			S_NORM: begin
				x_q  <= nx;
				sh_q <= sh_q + nadd;
			end
			S_SQ0: frac_q <= '0;
			S_SQ: begin
				frac_q <= frac_nx;
				if (cnt_q == bm25_pkg::LOG_STEPS - 5'd1) begin
					if (second_q) begin
						lb_q <= log_val;
					end else begin
						la_q <= log_val;
						x_q  <= {1'b0, df_q, 1'b1};
						sh_q <= '0;
					end
				end
			end
			S_IDF:   neg_q <= lb_q > la_q;
			S_IDFR:  idf_mag_q <= idf_rnd[53:32];
			S_RWAIT: r_q <= div_quot;
			S_N2:    norm_q <= 50'(bm25_pkg::ONE_Q16 - b_c) + 50'(p_q[48:0]);
			S_N3:    norm_q <= norm_q + 50'(p_q[32:16]);
			S_K2:    den_q <= 64'({tf_q, 28'd0}) + 64'(p_q[45:0]);
			S_K3:    den_q <= den_q + {p_q[31:0], 32'd0};
			S_K4:    den_zero_q <= (den_q == 64'd0);
			S_W:     wmag_q <= w_rnd[42:16];
			default: ;
		endcase
	end

	assign score_out.valid = out_v_q;
	assign score_out.score = score_q;

	// A divider start never lands on a running division
	assert property (@(posedge clk) disable iff (!arst_n) div_req.start |-> !div_busy)
		else $error("divider started while busy");

	// After a term is taken the block stays busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(term_in.valid && term_in.ready) |=> !term_in.ready)
		else $error("term taken while previous term in flight");

	// The score only moves together with a fresh score word
	assert property (@(posedge clk) disable iff (!arst_n) !$stable(score_q) |-> out_v_q)
		else $error("score changed without a score word");

endmodule
